// ===== rtl/core/tea_pkg.sv =====
package tea_pkg;

   // fixed field widths
   localparam int INDEX_W  = 10;
   localparam int EDGE_W   = 2;
   localparam int VERTEX_W = 12;
   localparam int NB_W     = 11;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 11;
   localparam int CORNERS  = 3;

   localparam int DEF_MAX_TRIANGLES = 1024;

   localparam logic KIND_WRITE   = 1'b0;
   localparam logic KIND_RESOLVE = 1'b1;

   localparam logic [EDGE_W-1:0] EDGE_NONE = 2'd3;

   localparam logic signed [NB_W-1:0] NO_NEIGHBOUR = '1;

   typedef enum logic [STATUS_W-1:0] {
      ST_STORED = 3'd0,
      ST_PAIRED = 3'd1,
      ST_NONE   = 3'd2,
      ST_SHARED = 3'd3,
      ST_LINKED = 3'd4,
      ST_BAD    = 3'd5
   } status_type;

   typedef struct packed {
      logic                kind;
      logic [INDEX_W-1:0]  triangle_index;
      logic [EDGE_W-1:0]   edge_select;
      logic [VERTEX_W-1:0] vertex_a;
      logic [VERTEX_W-1:0] vertex_b;
      logic [VERTEX_W-1:0] vertex_c;
   } req_type;

   typedef struct packed {
      logic signed [NB_W-1:0] neighbour;
      status_type             status;
   } rsp_type;

   // one stored triangle, corner 0 in the low bits
   typedef logic [CORNERS-1:0][VERTEX_W-1:0] corner_row_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_WRITE,
      S_LOOK,
      S_CHECK,
      S_SCAN,
      S_DECIDE,
      S_LINK_PART,
      S_LINK_OWN,
      S_REPLY
   } state_type;

   typedef enum logic [1:0] {
      RES_BAD,
      RES_STORED,
      RES_LINKED,
      RES_SCAN
   } res_type;

   typedef struct packed {
      logic    capture;
      logic    wr_store;
      logic    rd_own;
      logic    load_edge;
      logic    scan_clear;
      logic    scan_run;
      logic    wr_part;
      logic    wr_own;
      logic    res_load;
      res_type res_sel;
      logic    rsp_load;
   } cmd_type;

   typedef struct packed {
      logic bad;
      logic is_write;
      logic linked;
      logic scan_done;
      logic paired;
      logic rsp_free;
   } stat_type;

   function automatic logic [EDGE_W-1:0] next_corner(input logic [EDGE_W-1:0] e);
      logic [EDGE_W-1:0] n;
      unique case (e)
         2'd0:    n = 2'd1;
         2'd1:    n = 2'd2;
         default: n = 2'd0;
      endcase
      return n;
   endfunction

   function automatic logic [VERTEX_W-1:0] pick_corner(input corner_row_type row,
                                                       input logic [EDGE_W-1:0] e);
      logic [VERTEX_W-1:0] v;
      unique case (e)
         2'd0:    v = row[0];
         2'd1:    v = row[1];
         default: v = row[2];
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/core/tea_ram.sv =====
module tea_ram
   #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
   )
   (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
   );

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/tea_ctrl.sv =====
module tea_ctrl
   import tea_pkg::*;
   (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
   );

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (stat.bad)           state_in = S_REPLY;
            else if (stat.is_write) state_in = S_WRITE;
            else                    state_in = S_LOOK;
         end
         S_WRITE:     state_in = S_REPLY;
         S_LOOK:      state_in = S_CHECK;
         S_CHECK: begin
            state_in = stat.linked ? S_REPLY : S_SCAN;
         end
         S_SCAN: begin
            if (stat.scan_done) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = stat.paired ? S_LINK_PART : S_REPLY;
         end
         S_LINK_PART: state_in = S_LINK_OWN;
         S_LINK_OWN:  state_in = S_REPLY;
         S_REPLY: begin
            if (stat.rsp_free) state_in = S_IDLE;
         end
         default:     state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_DECODE: begin
            cmd.res_load = stat.bad;
            cmd.res_sel  = RES_BAD;
         end
         S_WRITE: begin
            cmd.wr_store = 1'b1;
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_STORED;
         end
         S_LOOK: begin
            cmd.rd_own = 1'b1;
         end
         S_CHECK: begin
            cmd.res_load   = stat.linked;
            cmd.res_sel    = RES_LINKED;
            cmd.load_edge  = !stat.linked;
            cmd.scan_clear = !stat.linked;
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
         end
         S_DECIDE: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_SCAN;
         end
         S_LINK_PART: begin
            cmd.wr_part = 1'b1;
         end
         S_LINK_OWN: begin
            cmd.wr_own = 1'b1;
         end
         S_REPLY: begin
            cmd.rsp_load = stat.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== rtl/core/tea_datapath.sv =====
module tea_datapath
   import tea_pkg::*;
   #(
   parameter int MAX_TRIANGLES = DEF_MAX_TRIANGLES
   )
   (
   input  logic               clock,
   input  logic               reset,
   input  req_type            req_data,
   output rsp_type            rsp_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data,
   input  cmd_type            cmd,
   output stat_type           stat
   );

   localparam int AW = $clog2(MAX_TRIANGLES);
   localparam int CW = $clog2(MAX_TRIANGLES + 1);
   localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;

   req_type                item_ff;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          scan_ff, scan_in;
   logic                   pend_ff;
   logic [AW-1:0]          cmp_addr_ff;
   logic [VERTEX_W-1:0]    v0_ff, v1_ff;
   logic                   first_valid_ff, first_valid_in;
   logic [AW-1:0]          first_tri_ff, first_tri_in;
   logic [EDGE_W-1:0]      first_edge_ff, first_edge_in;
   logic                   dup_ff, dup_in;
   rsp_type                res_ff, res_in;
   rsp_type                rsp_data_ff;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [AW-1:0]          own_addr;
   logic                   issue;
   corner_row_type         corner_rd;
   logic                   corner_rd_en;
   logic [AW-1:0]          corner_rd_addr;
   logic [NB_W-1:0]        link_rd [CORNERS];
   logic signed [NB_W-1:0] own_link;
   logic [CORNERS-1:0]     hit;
   logic                   self_hit;
   logic [EDGE_W-1:0]      hit_edge;
   logic                   multi_hit;

   assign own_addr = AW'(item_ff.triangle_index);

   // count register, clamped to the table size on write
   always_comb begin
      count_in = count_ff;
      if (csr_wr_en) begin
         if (XW'(csr_wr_data) > XW'(MAX_TRIANGLES)) count_in = CW'(MAX_TRIANGLES);
         else                                      count_in = CW'(csr_wr_data);
      end
   end

   // scan address counter
   assign issue = cmd.scan_run && (scan_ff < count_ff);

   always_comb begin
      scan_in = scan_ff;
      if (cmd.scan_clear) scan_in = '0;
      else if (issue)     scan_in = scan_ff + CW'(1);
   end

   assign corner_rd_en   = cmd.rd_own | issue;
   assign corner_rd_addr = cmd.rd_own ? own_addr : AW'(scan_ff);

   tea_ram #(
      .WIDTH (CORNERS * VERTEX_W),
      .DEPTH (MAX_TRIANGLES)
   ) u_corner_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_store),
      .wr_addr (own_addr),
      .wr_data ({item_ff.vertex_c, item_ff.vertex_b, item_ff.vertex_a}),
      .rd_en   (corner_rd_en),
      .rd_addr (corner_rd_addr),
      .rd_data (corner_rd)
   );

   // one neighbour ram per edge slot
   for (genvar g = 0; g < CORNERS; g++) begin : g_link
      logic            we;
      logic [AW-1:0]   wa;
      logic [NB_W-1:0] wd;

      always_comb begin
         we = 1'b0;
         wa = own_addr;
         wd = NO_NEIGHBOUR;
         if (cmd.wr_store) begin
            we = 1'b1;
         end else if (cmd.wr_part && (first_edge_ff == EDGE_W'(g))) begin
            we = 1'b1;
            wa = first_tri_ff;
            wd = NB_W'(item_ff.triangle_index);
         end else if (cmd.wr_own && (item_ff.edge_select == EDGE_W'(g))) begin
            we = 1'b1;
            wd = NB_W'(first_tri_ff);
         end
      end

      tea_ram #(
         .WIDTH (NB_W),
         .DEPTH (MAX_TRIANGLES)
      ) u_link_ram (
         .clock   (clock),
         .wr_en   (we),
         .wr_addr (wa),
         .wr_data (wd),
         .rd_en   (cmd.rd_own),
         .rd_addr (own_addr),
         .rd_data (link_rd[g])
      );
   end

   always_comb begin
      case (item_ff.edge_select)
         2'd0:    own_link = link_rd[0];
         2'd1:    own_link = link_rd[1];
         default: own_link = link_rd[2];
      endcase
   end

   // edge compare against the scanned row
   always_comb begin
      for (int j = 0; j < CORNERS; j++) begin
         hit[j] = ((v0_ff == corner_rd[j]) && (v1_ff == corner_rd[(j + 1) % CORNERS])) ||
                  ((v1_ff == corner_rd[j]) && (v0_ff == corner_rd[(j + 1) % CORNERS]));
      end
   end

   assign self_hit  = (cmp_addr_ff == own_addr);
   assign hit_edge  = hit[0] ? 2'd0 : (hit[1] ? 2'd1 : 2'd2);
   assign multi_hit = (hit[0] & hit[1]) | (hit[0] & hit[2]) | (hit[1] & hit[2]);

   always_comb begin
      first_valid_in = first_valid_ff;
      first_tri_in   = first_tri_ff;
      first_edge_in  = first_edge_ff;
      dup_in         = dup_ff;
      if (cmd.scan_clear) begin
         first_valid_in = 1'b0;
         dup_in         = 1'b0;
      end else if (pend_ff && !self_hit && (|hit)) begin
         if (!first_valid_ff) begin
            first_valid_in = 1'b1;
            first_tri_in   = cmp_addr_ff;
            first_edge_in  = hit_edge;
            dup_in         = multi_hit;
         end else begin
            dup_in = 1'b1;
         end
      end
   end

   // result word
   always_comb begin
      res_in = res_ff;
      if (cmd.res_load) begin
         case (cmd.res_sel)
            RES_STORED: res_in = '{neighbour: NO_NEIGHBOUR, status: ST_STORED};
            RES_LINKED: res_in = '{neighbour: own_link, status: ST_LINKED};
            RES_SCAN: begin
               if (dup_ff)
                  res_in = '{neighbour: NO_NEIGHBOUR, status: ST_SHARED};
               else if (first_valid_ff)
                  res_in = '{neighbour: NB_W'(first_tri_ff), status: ST_PAIRED};
               else
                  res_in = '{neighbour: NO_NEIGHBOUR, status: ST_NONE};
            end
            default:    res_in = '{neighbour: NO_NEIGHBOUR, status: ST_BAD};
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load)  rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= CW'(1);
         scan_ff        <= '0;
         pend_ff        <= 1'b0;
         first_valid_ff <= 1'b0;
         dup_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         count_ff       <= count_in;
         scan_ff        <= scan_in;
         pend_ff        <= issue;
         first_valid_ff <= first_valid_in;
         dup_ff         <= dup_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
      end
      if (cmd.load_edge) begin
         v0_ff <= pick_corner(corner_rd, item_ff.edge_select);
         v1_ff <= pick_corner(corner_rd, next_corner(item_ff.edge_select));
      end
      if (issue) begin
         cmp_addr_ff <= AW'(scan_ff);
      end
      first_tri_ff  <= first_tri_in;
      first_edge_ff <= first_edge_in;
      res_ff        <= res_in;
      if (cmd.rsp_load) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign stat.bad       = (XW'(item_ff.triangle_index) >= XW'(count_ff)) ||
                           ((item_ff.kind == KIND_RESOLVE) &&
                            (item_ff.edge_select == EDGE_NONE));
   assign stat.is_write  = (item_ff.kind == KIND_WRITE);
   assign stat.linked    = (own_link != NO_NEIGHBOUR);
   assign stat.scan_done = (scan_ff == count_ff) && !pend_ff;
   assign stat.paired    = first_valid_ff && !dup_ff;
   assign stat.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/triangle_edge_adjacency.sv =====
// triangle edge adjacency: a table of up to MAX_TRIANGLES triangles, each with
// three corner vertex indices and three neighbour slots. a write word stores a
// triangle and clears its slots; a resolve word returns the slot's neighbour if
// already linked, otherwise scans every other entry below the triangle count for
// the same vertex pair in either order and links both sides on a unique match.
// one word is in work at a time; a finished result sits in the output register
// while the next word is taken, which can happen in the same cycle the result
// goes valid. a scanning resolve reads the corner ram one entry per cycle
// through its single read port, compares each row on the ram's registered read
// data, and when it pairs writes both link slots before the result goes out.
// unwritten entries read as garbage, so all entries below the count must be
// written before resolving. no clearing pass after reset
module triangle_edge_adjacency
   import tea_pkg::*;
   #(
   parameter int MAX_TRIANGLES = DEF_MAX_TRIANGLES
   )
   (
   input  logic               clock,
   input  logic               reset,
   // input words
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   // result words
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data,
   // triangle count register
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data
   );

   cmd_type  cmd;
   stat_type stat;

   // sequencer: decode, own row lookup, scan, link writes, reply
   tea_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // corner and neighbour rams, scan compare, result register
   tea_datapath #(
      .MAX_TRIANGLES (MAX_TRIANGLES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .rsp_data    (rsp_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule

// ===== rtl/core/tea_checker.sv =====
module tea_checker
   import tea_pkg::*;
   (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
   );

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // one word in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while a word is in work");

   // results without a partner carry no neighbour
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_STORED || rsp_data.status == ST_NONE ||
                    rsp_data.status == ST_SHARED || rsp_data.status == ST_BAD)
      |-> rsp_data.neighbour == NO_NEIGHBOUR)
      else $error("neighbour set on a result without a partner");

   // paired and linked results name a real neighbour
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_PAIRED || rsp_data.status == ST_LINKED)
      |-> rsp_data.neighbour != NO_NEIGHBOUR)
      else $error("paired result without a neighbour");

endmodule

bind triangle_edge_adjacency tea_checker u_tea_checker (.*);

// ===== verif/triangle_edge_adjacency_chk.sv =====
module triangle_edge_adjacency_chk
   import tea_pkg::*;
   #(
   parameter int MAX_TRIANGLES = DEF_MAX_TRIANGLES
   )
   (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  req_type            req_data,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  rsp_type            rsp_data,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data,
   input  logic               sim_done,
   output int                 failures
   );

   // own copy of the mesh table
   corner_row_type         corners [MAX_TRIANGLES];
   logic signed [NB_W-1:0] links [MAX_TRIANGLES][CORNERS];
   logic [COUNT_W-1:0]     tri_count;

   rsp_type mesh_answers [$];
   int      errors = 0;
   bit      end_checked = 1'b0;

   assign failures = errors;

   task automatic flag(input string msg);
      errors++;
      $display("mismatch at %0t: %s", $time, msg);
   endtask

   // applies one word to the table and gives the result it should produce
   function automatic rsp_type mesh_apply(input req_type w);
      rsp_type             r;
      int                  span;
      int                  idx;
      int                  e;
      int                  hits;
      int                  hit_tri;
      int                  hit_edge;
      logic [VERTEX_W-1:0] v0;
      logic [VERTEX_W-1:0] v1;
      logic [VERTEX_W-1:0] a;
      logic [VERTEX_W-1:0] b;
      span = (tri_count > MAX_TRIANGLES) ? MAX_TRIANGLES : int'(tri_count);
      idx = int'(w.triangle_index);
      e = int'(w.edge_select);
      r.neighbour = NO_NEIGHBOUR;
      r.status = ST_BAD;
      hits = 0;
      hit_tri = 0;
      hit_edge = 0;
      if (idx >= span) return r;
      if (w.kind == KIND_WRITE) begin
         corners[idx][0] = w.vertex_a;
         corners[idx][1] = w.vertex_b;
         corners[idx][2] = w.vertex_c;
         for (int j = 0; j < CORNERS; j++) links[idx][j] = NO_NEIGHBOUR;
         r.status = ST_STORED;
         return r;
      end
      if (w.edge_select == EDGE_NONE) return r;
      if (links[idx][e] != NO_NEIGHBOUR) begin
         r.neighbour = links[idx][e];
         r.status = ST_LINKED;
         return r;
      end
      v0 = corners[idx][e];
      v1 = corners[idx][(e + 1) % CORNERS];
      // every (triangle, edge) hit counts, so a doubled edge counts twice
      for (int k = 0; k < span; k++) begin
         if (k != idx) begin
            for (int j = 0; j < CORNERS; j++) begin
               a = corners[k][j];
               b = corners[k][(j + 1) % CORNERS];
               if ((v0 == a && v1 == b) || (v0 == b && v1 == a)) begin
                  if (hits == 0) begin
                     hit_tri = k;
                     hit_edge = j;
                  end
                  hits++;
               end
            end
         end
      end
      if (hits > 1) begin
         r.status = ST_SHARED;
      end else if (hits == 0) begin
         r.status = ST_NONE;
      end else begin
         links[hit_tri][hit_edge] = idx[NB_W-1:0];
         links[idx][e] = hit_tri[NB_W-1:0];
         r.neighbour = hit_tri[NB_W-1:0];
         r.status = ST_PAIRED;
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         tri_count = COUNT_W'(1);
         mesh_answers.delete();
      end else begin
         if (csr_wr_en) tri_count = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (mesh_answers.size() == 0) begin
               flag("result word with nothing outstanding");
            end else begin
               want = mesh_answers.pop_front();
               if (rsp_data.neighbour !== want.neighbour)
                  flag($sformatf("neighbour %0d, expected %0d",
                                 rsp_data.neighbour, want.neighbour));
               if (rsp_data.status !== want.status)
                  flag($sformatf("status %0d, expected %0d",
                                 rsp_data.status, want.status));
            end
         end
         if (req_valid && req_ready) mesh_answers.push_back(mesh_apply(req_data));
         if (sim_done && !end_checked) begin
            end_checked = 1'b1;
            if (mesh_answers.size() != 0)
               flag($sformatf("%0d results never arrived", mesh_answers.size()));
         end
      end
   end

endmodule

// ===== verif/triangle_edge_adjacency_tb.sv =====
module triangle_edge_adjacency_tb;
   import tea_pkg::*;

   localparam int TABLE_SIZE = DEF_MAX_TRIANGLES;
   localparam int COUNT_TOP  = (1 << COUNT_W) - 1;

   // directed corner values, extremes and alternating bits
   localparam int VA = 0;
   localparam int VB = 4095;
   localparam int VC = 'haaa;
   localparam int VD = 'h555;
   localparam int VE = 4094;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   req_type            req_data = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   rsp_type            rsp_data;
   logic               csr_wr_en = 1'b0;
   logic [COUNT_W-1:0] csr_wr_data = '0;
   logic               sim_done = 1'b0;
   int                 failures;

   // word bookkeeping, one result per input word
   int words_sent = 0;
   int results_seen = 0;

   // idle knobs, percent per cycle
   int gap_pct = 0;
   int stall_pct = 0;

   // count as the block applies it, and which entries hold a triangle
   int live_count = 1;
   bit written [TABLE_SIZE];

   // vertex numbering for the current phase
   logic [VERTEX_W-1:0] vert_base = '0;
   int                  pool_span = 3;

   always #10 clock = ~clock;

   triangle_edge_adjacency dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   triangle_edge_adjacency_chk adjacency_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .sim_done    (sim_done),
      .failures    (failures)
   );

   // hard stop well past the slowest legal run
   initial begin
      #10_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // result side: count words taken, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) results_seen++;
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic req_type make_word(input logic kind, input int idx, input int edge_no,
                                         input int va, input int vb, input int vc);
      req_type w;
      w.kind           = kind;
      w.triangle_index = idx[INDEX_W-1:0];
      w.edge_select    = edge_no[EDGE_W-1:0];
      w.vertex_a       = va[VERTEX_W-1:0];
      w.vertex_b       = vb[VERTEX_W-1:0];
      w.vertex_c       = vc[VERTEX_W-1:0];
      return w;
   endfunction

   // triangle write: half a strip (clean shared edges), else a small vertex pool
   // (repeats, edges shared by three), some degenerate, some fully random
   function automatic req_type tri_word(input int idx);
      int                  r;
      logic [VERTEX_W-1:0] a;
      logic [VERTEX_W-1:0] b;
      logic [VERTEX_W-1:0] c;
      r = $urandom_range(99);
      if (r < 50) begin
         a = vert_base + idx[VERTEX_W-1:0];
         b = a + 1'b1;
         c = a + 2'd2;
      end else if (r < 88) begin
         a = vert_base + VERTEX_W'($urandom_range(pool_span - 1));
         b = vert_base + VERTEX_W'($urandom_range(pool_span - 1));
         c = vert_base + VERTEX_W'($urandom_range(pool_span - 1));
      end else if (r < 94) begin
         // two equal corners, so one edge can match twice
         a = vert_base + VERTEX_W'($urandom_range(pool_span - 1));
         b = vert_base + VERTEX_W'($urandom_range(pool_span - 1));
         c = a;
      end else begin
         a = VERTEX_W'($urandom);
         b = VERTEX_W'($urandom);
         c = VERTEX_W'($urandom);
      end
      return make_word(KIND_WRITE, idx, $urandom_range(3), a, b, c);
   endfunction

   // vertex fields are don't-care on a resolve, keep them noisy
   function automatic req_type resolve_word(input int idx, input int edge_no);
      return make_word(KIND_RESOLVE, idx, edge_no, $urandom, $urandom, $urandom);
   endfunction

   // valid stays up across back-to-back words; dropped only for a gap
   task automatic push_word(input req_type w);
      if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_data  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      if (w.kind == KIND_WRITE && w.triangle_index < live_count)
         written[w.triangle_index] = 1'b1;
   endtask

   // hold off until every result is back
   task automatic settle();
      req_valid <= 1'b0;
      while (results_seen != words_sent) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic set_count(input int value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[COUNT_W-1:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      live_count = (value > TABLE_SIZE) ? TABLE_SIZE : value;
   endtask

   task automatic set_idle(input int mode);
      case (mode)
         1: begin
            gap_pct = 71;
            stall_pct = 0;
         end
         2: begin
            gap_pct = 0;
            stall_pct = 71;
         end
         3: begin
            gap_pct = 11;
            stall_pct = 11;
         end
         default: begin
            gap_pct = 0;
            stall_pct = 0;
         end
      endcase
   endtask

   // one setting of the count: fill the table with a fresh mesh (count of 128 or less), then a random mix
   task automatic run_phase(input int count_value, input int n_items, input int mode);
      int r;
      int idx;
      bit table_ready;
      set_count(count_value);
      set_idle(mode);
      vert_base = VERTEX_W'($urandom);
      pool_span = 3 + live_count / 4;
      if (live_count <= 128)
         for (idx = 0; idx < live_count; idx++) push_word(tri_word(idx));
      // no resolve may touch an entry that never held a triangle
      table_ready = 1'b1;
      for (idx = 0; idx < live_count; idx++)
         if (!written[idx]) table_ready = 1'b0;
      repeat (n_items) begin
         r = $urandom_range(99);
         if (live_count == 0 || (r < 10 && live_count < TABLE_SIZE)) begin
            // index past the count, write or resolve
            idx = $urandom_range(TABLE_SIZE - 1, live_count);
            if (r[0]) push_word(tri_word(idx));
            else push_word(resolve_word(idx, $urandom_range(3)));
         end else if (!table_ready || r < 30) begin
            push_word(tri_word($urandom_range(live_count - 1)));
         end else if (r < 34) begin
            push_word(resolve_word($urandom_range(live_count - 1), EDGE_NONE));
         end else if (r < 36) begin
            settle();
         end else begin
            push_word(resolve_word($urandom_range(live_count - 1), $urandom_range(2)));
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // count is one out of reset: single entry, bad index and edge three
      push_word(make_word(KIND_WRITE, 0, 0, VA, VB, VC));
      push_word(make_word(KIND_WRITE, 1, 2, VC, VD, VE));
      push_word(resolve_word(0, 0));
      push_word(resolve_word(0, EDGE_NONE));
      push_word(resolve_word(TABLE_SIZE - 1, 1));

      // small hand-built mesh
      set_count(5);
      push_word(make_word(KIND_WRITE, 0, 0, VA, VB, VC));
      push_word(make_word(KIND_WRITE, 1, 1, VC, VB, VD));
      push_word(make_word(KIND_WRITE, 2, 2, VA, VC, VE));
      push_word(make_word(KIND_WRITE, 3, 3, VE, VC, VA));
      push_word(make_word(KIND_WRITE, 4, 0, VD, VD, VD));
      push_word(resolve_word(0, 1));   // unique partner
      push_word(resolve_word(1, 0));   // now linked from the other side
      push_word(resolve_word(0, 2));   // shared by three
      push_word(resolve_word(2, 1));   // unique partner
      push_word(resolve_word(1, 1));   // no partner
      // partner slot already linked elsewhere gets overwritten
      push_word(make_word(KIND_WRITE, 2, 0, VA, VB, VD));
      push_word(make_word(KIND_WRITE, 4, 0, VE, VC, VD));
      push_word(resolve_word(4, 0));
      push_word(resolve_word(3, 0));
      // degenerate triangle matches one edge twice
      push_word(make_word(KIND_WRITE, 1, 0, VD, VE, VD));
      push_word(resolve_word(4, 2));

      // random phases across counts and idle patterns
      run_phase(0, 10, 1);
      run_phase(2, 30, 2);
      run_phase(3, 30, 3);
      run_phase(9, 40, 0);
      run_phase(1, 15, 1);
      run_phase(24, 50, 2);
      run_phase(40, 40, 3);
      run_phase(7, 40, 1);
      run_phase(60, 30, 0);
      run_phase(16, 50, 2);

      // full count, then a count past the top that clamps to it; most entries
      // hold no triangle, so only writes and edge three resolves go in here
      set_count(TABLE_SIZE);
      set_idle(0);
      push_word(tri_word(TABLE_SIZE - 1));
      push_word(tri_word($urandom_range(TABLE_SIZE - 1)));
      push_word(resolve_word(TABLE_SIZE - 1, EDGE_NONE));
      set_count(COUNT_TOP);
      set_idle(3);
      push_word(tri_word(TABLE_SIZE - 1));
      push_word(resolve_word($urandom_range(TABLE_SIZE - 1), EDGE_NONE));

      run_phase(5, 30, 3);

      // drain, let the block go quiet, then verdict
      settle();
      repeat (40) @(posedge clock);
      sim_done <= 1'b1;
      repeat (3) @(posedge clock);
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
